// File: hw/rtl/ptald_pkg.sv
// Shared types and constants of the peak-three average leak detector.
package ptald_pkg;

  // Widths of the sample path.
  localparam int unsigned SampleW = 12;
  localparam int unsigned SumW    = 14;

  // Reciprocal of three in 16 fractional bits; exact floor for sums below 2**14.
  localparam int unsigned RecipW    = 15;
  localparam int unsigned RecipFrac = 16;
  localparam int unsigned ProdW     = SumW + RecipW;
  localparam logic [RecipW-1:0] RecipThree = RecipW'(21846);

  // Reset value of the leak threshold.
  localparam logic [SampleW-1:0] ThresholdReset = SampleW'(1250);

  // Status codes of the held leak flag.
  localparam logic StatusLeak  = 1'b1;
  localparam logic StatusClear = 1'b0;

  // One end-of-window request from the ranking stage to the judging stage.
  typedef struct packed {
    logic [SumW-1:0] peak_sum;
    logic            green;
  } win_req_t;

  // Status of the ranking stage, observed at the top level.
  typedef struct packed {
    logic busy;
    logic end_pending;
  } rank_stat_t;

endpackage

// File: hw/rtl/ptald_rank.sv
// Input register, window counter and three-place compare-insert of the largest samples.
module ptald_rank #(
  parameter int unsigned WINDOW = 50
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ptald_pkg::SampleW-1:0] adc_sample_i,
  input  logic                          window_last_i,
  input  logic                          green_light_i,
  output logic                          req_valid_o,
  input  logic                          req_free_i,
  output ptald_pkg::win_req_t           req_o,
  output ptald_pkg::rank_stat_t         stat_o
);

  localparam int unsigned CntW = $clog2(WINDOW);

  logic                          in_valid_q;
  logic [ptald_pkg::SampleW-1:0] in_sample_q;
  logic                          in_last_q;
  logic                          in_green_q;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [ptald_pkg::SampleW-1:0] top0_q, top1_q, top2_q;
  logic [ptald_pkg::SampleW-1:0] top0_d, top1_d, top2_d;
  logic [ptald_pkg::SampleW-1:0] ins0, ins1, ins2;
  logic                          in_end;
  logic                          in_fire;
  logic                          in_free;

  // The held sample closes its window on the last flag or on the final count.
  assign in_end  = in_last_q || (cnt_q == CntW'(WINDOW - 1));
  assign in_fire = in_valid_q && (!in_end || req_free_i);
  assign in_free = !in_valid_q || in_fire;

  assign in_stall_o = !in_free;

  // Input register takes a new request whenever the held one moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_free) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      in_sample_q <= adc_sample_i;
      in_last_q   <= window_last_i;
      in_green_q  <= green_light_i;
    end
  end

  // Compare-insert of the held sample into the three largest values.
  always_comb begin
    ins0 = top0_q;
    ins1 = top1_q;
    ins2 = top2_q;
    if (in_sample_q > top0_q) begin
      ins0 = in_sample_q;
      ins1 = top0_q;
      ins2 = top1_q;
    end else if (in_sample_q > top1_q) begin
      ins1 = in_sample_q;
      ins2 = top1_q;
    end else if (in_sample_q > top2_q) begin
      ins2 = in_sample_q;
    end
  end

  // Window state: insert on an ordinary sample, clear after the closing one.
  always_comb begin
    top0_d = top0_q;
    top1_d = top1_q;
    top2_d = top2_q;
    cnt_d  = cnt_q;
    if (in_fire) begin
      if (in_end) begin
        top0_d = '0;
        top1_d = '0;
        top2_d = '0;
        cnt_d  = '0;
      end else begin
        top0_d = ins0;
        top1_d = ins1;
        top2_d = ins2;
        cnt_d  = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top0_q <= '0;
      top1_q <= '0;
      top2_q <= '0;
      cnt_q  <= '0;
    end else begin
      top0_q <= top0_d;
      top1_q <= top1_d;
      top2_q <= top2_d;
      cnt_q  <= cnt_d;
    end
  end

  // Sum of the three largest values including the closing sample.
  assign req_valid_o     = in_valid_q && in_end;
  assign req_o.peak_sum  = ptald_pkg::SumW'(ins0) + ptald_pkg::SumW'(ins1)
                         + ptald_pkg::SumW'(ins2);
  assign req_o.green     = in_green_q;

  assign stat_o.busy        = in_valid_q;
  assign stat_o.end_pending = in_valid_q && in_end;

endmodule

// File: hw/rtl/ptald_judge.sv
// Sum register, division by three, threshold judgment and result register.
module ptald_judge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_free_o,
  input  ptald_pkg::win_req_t           req_i,
  input  logic [ptald_pkg::SampleW-1:0] threshold_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ptald_pkg::SampleW-1:0] peak_average_o,
  output logic                          leak_status_o
);

  logic                          sum_valid_q;
  ptald_pkg::win_req_t           sum_q;
  logic                          out_valid_q;
  logic [ptald_pkg::SampleW-1:0] avg_q;
  logic                          held_q, held_d;
  logic [ptald_pkg::ProdW-1:0]   prod;
  logic [ptald_pkg::SampleW-1:0] avg;
  logic                          out_free;
  logic                          sum_free;
  logic                          sum_move;

  assign out_free = !out_valid_q || !out_stall_i;
  assign sum_move = sum_valid_q && out_free;
  assign sum_free = !sum_valid_q || out_free;

  assign req_free_o = sum_free;

  // Sum register between the ranking and the judging logic.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (sum_free) begin
      sum_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_free && req_valid_i) begin
      sum_q <= req_i;
    end
  end

  // Floor of the sum over three by multiplying with the scaled reciprocal.
  assign prod = ptald_pkg::ProdW'(sum_q.peak_sum) * ptald_pkg::ProdW'(ptald_pkg::RecipThree);
  assign avg  = prod[ptald_pkg::RecipFrac +: ptald_pkg::SampleW];

  // Leak flag is judged only under green light, otherwise it is held.
  always_comb begin
    held_d = held_q;
    if (sum_move && sum_q.green) begin
      held_d = (avg < threshold_i) ? ptald_pkg::StatusLeak : ptald_pkg::StatusClear;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= ptald_pkg::StatusClear;
      out_valid_q <= 1'b0;
    end else begin
      held_q <= held_d;
      if (out_free) begin
        out_valid_q <= sum_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_move) begin
      avg_q <= avg;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign peak_average_o = avg_q;
  assign leak_status_o  = held_q;

endmodule

// File: hw/rtl/peak_three_average_leak_detector.sv
// Top level of the peak-three average leak detector.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_stall_o    adc_sample_i, window_last_i, green_light_i
//   out      output     out_valid_o/out_stall_i  peak_average_o, leak_status_o
//   cfg      input      cfg_valid_i/cfg_ready_o  leak_threshold_i
//
// One sample is taken every cycle while the input is not stalled; the three-place
// compare-insert in the ranking stage handles one sample per cycle. A window result
// passes from the input register through the sum register to the result register.
// Reset clears the window registers, the count and the held status, and sets the threshold (1250).
// A stalled result holds; samples are still taken until a closing sample finds the sum
// register and the result register both occupied.
module peak_three_average_leak_detector #(
  parameter int unsigned WINDOW = 50
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ptald_pkg::SampleW-1:0] adc_sample_i,
  input  logic                          window_last_i,
  input  logic                          green_light_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ptald_pkg::SampleW-1:0] peak_average_o,
  output logic                          leak_status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ptald_pkg::SampleW-1:0] leak_threshold_i
);

  logic [ptald_pkg::SampleW-1:0] threshold_q;
  logic                          req_valid;
  logic                          req_free;
  ptald_pkg::win_req_t           req;
  ptald_pkg::rank_stat_t         rank_stat;

  // Threshold register, always ready for a write request.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ptald_pkg::ThresholdReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      threshold_q <= leak_threshold_i;
    end
  end

  // Ranking of the window's samples.
  ptald_rank #(
    .WINDOW (WINDOW)
  ) u_rank (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .adc_sample_i  (adc_sample_i),
    .window_last_i (window_last_i),
    .green_light_i (green_light_i),
    .req_valid_o   (req_valid),
    .req_free_i    (req_free),
    .req_o         (req),
    .stat_o        (rank_stat)
  );

  // Average and leak judgment per window.
  ptald_judge u_judge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid),
    .req_free_o     (req_free),
    .req_i          (req),
    .threshold_i    (threshold_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .peak_average_o (peak_average_o),
    .leak_status_o  (leak_status_o)
  );

  // The input side stalls only behind a closing sample that cannot move on.
  a_stall_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> rank_stat.end_pending)
    else $error("input stalled without a pending window end");

  // With an empty result register the input side never stalls.
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the result register is empty");

  // The held status only changes when a new result is loaded.
  a_status_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (leak_status_o != $past(leak_status_o)) |-> out_valid_o)
    else $error("leak status changed without a result");

  // A stall request always comes from a busy input register.
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> rank_stat.busy)
    else $error("input stalled with an empty input register");

endmodule

// File: verif/peak_three_average_leak_detector_tb.sv
// Self-checking testbench of the peak-three average leak detector with its own window predictor.
module peak_three_average_leak_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Window        = 50;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned WatchdogLimit = 4000;

  // How the sender spaces its requests and how the receiver stalls.
  typedef enum {GapNone, GapShort, GapLong} gap_mode_e;
  typedef enum {StallNone, StallLight, StallHeavy} stall_mode_e;

  // One window result as the block should present it.
  typedef struct packed {
    logic [ptald_pkg::SampleW-1:0] peak_average;
    logic                          leak_status;
  } window_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [ptald_pkg::SampleW-1:0] adc_sample;
  logic                          window_last;
  logic                          green_light;
  logic                          out_valid;
  logic                          out_stall;
  logic [ptald_pkg::SampleW-1:0] peak_average;
  logic                          leak_status;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [ptald_pkg::SampleW-1:0] cfg_threshold;

  // Predictor state: the top three of the open window and the held status.
  logic [ptald_pkg::SampleW-1:0] top_first;
  logic [ptald_pkg::SampleW-1:0] top_second;
  logic [ptald_pkg::SampleW-1:0] top_third;
  int unsigned                   win_count;
  logic                          held_leak;
  logic [ptald_pkg::SampleW-1:0] threshold;

  window_result_t     window_results_q[$];
  int unsigned        error_count;
  int unsigned        samples_sent;
  int unsigned        burst_left;
  gap_mode_e          gap_mode;
  stall_mode_e        stall_mode;
  bit                 holdoff_req;

  peak_three_average_leak_detector #(
    .WINDOW(Window)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .adc_sample_i    (adc_sample),
    .window_last_i   (window_last),
    .green_light_i   (green_light),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .peak_average_o  (peak_average),
    .leak_status_o   (leak_status),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .leak_threshold_i(cfg_threshold)
  );

  // Free-running clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Ranks one accepted sample and, when it closes the window, predicts the result.
  task automatic rank_and_judge(input logic [ptald_pkg::SampleW-1:0] sample, input logic last,
                                input logic green);
    logic [ptald_pkg::SumW-1:0] peak_sum;
    window_result_t             res;
    if (sample > top_first) begin
      top_third  = top_second;
      top_second = top_first;
      top_first  = sample;
    end else if (sample > top_second) begin
      top_third  = top_second;
      top_second = sample;
    end else if (sample > top_third) begin
      top_third = sample;
    end
    if (!last && win_count < Window - 1) begin
      win_count++;
    end else begin
      peak_sum = ptald_pkg::SumW'(top_first) + ptald_pkg::SumW'(top_second)
               + ptald_pkg::SumW'(top_third);
      res.peak_average = ptald_pkg::SampleW'(peak_sum / 3);
      // The leak judgement only happens under green light; otherwise the old status holds.
      if (green) begin
        held_leak = (res.peak_average < threshold) ? ptald_pkg::StatusLeak
                                                   : ptald_pkg::StatusClear;
      end
      res.leak_status = held_leak;
      window_results_q.push_back(res);
      top_first  = '0;
      top_second = '0;
      top_third  = '0;
      win_count  = 0;
    end
  endtask

  // Offers one sample request, spacing bursts by the current gap mode.
  task automatic send_sample(input logic [ptald_pkg::SampleW-1:0] sample, input logic last,
                             input logic green);
    int unsigned gap;
    if (burst_left == 0) begin
      case (gap_mode)
        GapShort: begin
          gap        = $urandom_range(0, 3);
          burst_left = $urandom_range(1, 30);
        end
        GapLong: begin
          gap        = $urandom_range(0, 20);
          burst_left = $urandom_range(1, 8);
        end
        default: begin
          gap        = 0;
          burst_left = 1000;
        end
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    adc_sample  <= sample;
    window_last <= last;
    green_light <= green;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    rank_and_judge(sample, last, green);
  endtask

  // Withdraws the sender; time advances so that a following request is a fresh one.
  task automatic stop_input();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (window_results_q.size() != 0) @(posedge clk);
  endtask

  // Writes the threshold once the block has gone quiet.
  task automatic set_threshold(input logic [ptald_pkg::SampleW-1:0] value);
    stop_input();
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_threshold <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    threshold = value;
  endtask

  // Picks a sample value: extremes, values near the threshold, or anything.
  function automatic logic [ptald_pkg::SampleW-1:0] pick_sample();
    int value;
    case ($urandom_range(0, 7))
      0: value = $urandom_range(0, 15);
      1: value = $urandom_range(4080, 4095);
      2, 3: value = int'(threshold) + $urandom_range(0, 16) - 8;
      default: value = $urandom_range(0, 4095);
    endcase
    if (value < 0) value = 0;
    if (value > 4095) value = 4095;
    return ptald_pkg::SampleW'(value);
  endfunction

  // Sends one window: mostly well formed, some running past the window size, some noise.
  task automatic send_window();
    int unsigned len;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3, 4: len = $urandom_range(1, 6);
      5, 6:          len = $urandom_range(7, 49);
      7:             len = Window;
      8:             len = $urandom_range(Window, Window + 12);
      default:       len = $urandom_range(1, 4);
    endcase
    for (int unsigned i = 0; i < len; i++) begin
      if (kind == 8) begin
        // No closing flag: the block must close the window on its own.
        send_sample(pick_sample(), 1'b0, 1'($urandom));
      end else if (kind == 9) begin
        send_sample(pick_sample(), 1'($urandom), 1'($urandom));
      end else begin
        send_sample(pick_sample(), 1'(i == len - 1), 1'($urandom));
      end
    end
  endtask

  // Directed windows at the reset threshold: boundary, short windows, duplicates, held status.
  task automatic test_directed_windows();
    gap_mode   = GapShort;
    stall_mode = StallLight;
    // Just below the threshold under green light: leakage.
    repeat (2) send_sample(12'd1249, 1'b0, 1'b0);
    send_sample(12'd1249, 1'b1, 1'b1);
    // Exactly at the threshold: no leakage.
    repeat (2) send_sample(12'd1250, 1'b0, 1'b1);
    send_sample(12'd1250, 1'b1, 1'b1);
    // One-sample window without green light: the missing places count as zero.
    send_sample(12'd4095, 1'b1, 1'b0);
    // Two-sample window under green light.
    send_sample(12'd4095, 1'b0, 1'b0);
    send_sample(12'd4094, 1'b1, 1'b1);
    // Duplicates all count towards the top three.
    send_sample(12'd7, 1'b0, 1'b0);
    send_sample(12'd9, 1'b0, 1'b1);
    send_sample(12'd9, 1'b0, 1'b0);
    send_sample(12'd3, 1'b0, 1'b1);
    send_sample(12'd9, 1'b1, 1'b1);
    // Full-scale window without green light keeps the leak status.
    repeat (3) send_sample(12'd4095, 1'b0, 1'b1);
    send_sample(12'd0, 1'b1, 1'b0);
    // All-zero window.
    send_sample(12'd0, 1'b1, 1'b1);
    stop_input();
  endtask

  // Threshold extremes around full scale and zero.
  task automatic test_threshold_extremes();
    set_threshold(12'd0);
    send_sample(12'd0, 1'b1, 1'b1);
    send_sample(12'd4095, 1'b1, 1'b1);
    set_threshold(12'd4095);
    send_sample(12'd4094, 1'b0, 1'b0);
    send_sample(12'd4095, 1'b0, 1'b0);
    send_sample(12'd4095, 1'b1, 1'b1);
    repeat (2) send_sample(12'd4095, 1'b0, 1'b0);
    send_sample(12'd4095, 1'b1, 1'b1);
    set_threshold(12'd1);
    send_sample(12'd0, 1'b1, 1'b1);
    stop_input();
  endtask

  // Random windows under one threshold and one idling pattern.
  task automatic test_random_stream(input int unsigned n_samples,
                                    input logic [ptald_pkg::SampleW-1:0] thr,
                                    input gap_mode_e gaps, input stall_mode_e stalls);
    int unsigned first;
    set_threshold(thr);
    gap_mode   = gaps;
    stall_mode = stalls;
    first      = samples_sent;
    while (samples_sent - first < n_samples) send_window();
    stop_input();
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    int unsigned len;
    set_threshold(12'($urandom_range(0, 4095)));
    gap_mode    = GapNone;
    stall_mode  = StallNone;
    holdoff_req = 1'b1;
    repeat (60) begin
      len = $urandom_range(1, 3);
      for (int unsigned i = 0; i < len; i++) begin
        send_sample(pick_sample(), 1'(i == len - 1), 1'($urandom));
      end
    end
    // The sender pauses until every result is back before going on.
    stop_input();
    wait_drained();
    stall_mode = StallHeavy;
    repeat (10) send_window();
    stop_input();
  endtask

  // Receiver: stall pattern of its own, with a long hold-off on request.
  always @(posedge clk) begin
    int unsigned     hold_left;
    int unsigned     phase;
    logic [15:0]     stall_pat;
    if (holdoff_req) begin
      holdoff_req = 1'b0;
      hold_left   = HoldOffCycles;
    end
    if (phase == 0) begin
      case (stall_mode)
        StallLight: stall_pat = 16'($urandom & $urandom);
        StallHeavy: stall_pat = 16'($urandom | $urandom);
        default:    stall_pat = '0;
      endcase
    end
    phase = (phase + 1) % 16;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= stall_pat[phase];
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    window_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (window_results_q.size() == 0) begin
        $error("unexpected result: peak_average %0d leak_status %0d", peak_average,
               leak_status);
        error_count++;
      end else begin
        want = window_results_q.pop_front();
        if (peak_average !== want.peak_average) begin
          $error("peak_average: expected %0d, actual %0d", want.peak_average, peak_average);
          error_count++;
        end
        if (leak_status !== want.leak_status) begin
          $error("leak_status: expected %0d, actual %0d", want.leak_status, leak_status);
          error_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    int unsigned quiet;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    adc_sample    = '0;
    window_last   = 1'b0;
    green_light   = 1'b0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_threshold = '0;
    holdoff_req   = 1'b0;
    gap_mode      = GapNone;
    stall_mode    = StallNone;
    burst_left    = 0;
    samples_sent  = 0;
    error_count   = 0;
    top_first     = '0;
    top_second    = '0;
    top_third     = '0;
    win_count     = 0;
    held_leak     = ptald_pkg::StatusClear;
    threshold     = ptald_pkg::ThresholdReset;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_windows();
    test_threshold_extremes();
    test_random_stream(500, 12'($urandom_range(0, 4095)), GapShort, StallLight);
    test_random_stream(450, ptald_pkg::ThresholdReset, GapNone, StallNone);
    test_random_stream(400, 12'($urandom_range(1000, 3000)), GapLong, StallHeavy);
    test_backpressure();
    test_random_stream(200, 12'd4095, GapShort, StallLight);

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && window_results_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
